// ===== rtl/linear_interp_resampler_top_defines.svh =====
// Assertion macros shared by the resampler RTL.
`ifndef LINEAR_INTERP_RESAMPLER_TOP_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_DEFINES_SVH

`ifndef SYNTH

// Check a property on a given clock with an active-low reset.
`define LIR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on the module's own clk_i and rst_ni.
`define LIR_ASSERT(lbl, prop, msg) \
  `LIR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define LIR_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define LIR_ASSERT(lbl, prop, msg)

`endif

`endif

// ===== rtl/lir_pkg.sv =====
// Shared types and constants of the linear interpolation resampler.
`timescale 1ns / 1ps

package lir_pkg;

  localparam int MAX_CH_DEF      = 8;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_W   = 32;
  localparam int CHAN_W     = 3;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = 24;
  localparam int CNT_W      = 4;
  localparam int SKIP_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [STEP_W-1:0] STEP_ONE = 24'h010000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_STEP_RATIO    = 2'd1
  } cfg_reg_e;

  // What travels with one item from the control stage into the datapath.
  typedef struct packed {
    logic              emit;
    logic              first;
    logic              last;
    logic [CHAN_W-1:0] chan;
    logic [FRAC_W-1:0] frac;
  } lir_tag_t;

endpackage

// ===== rtl/lir_mem.sv =====
// Per-channel held-sample memory, single port, read-first, registered read.
`timescale 1ns / 1ps

module lir_mem #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 3
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] held_mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Read the old entry and write the new sample in the same beat.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q          <= held_mem[addr_i];
      held_mem[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lir_ctrl.sv =====
// Configuration registers, input handshake and position tracking of the resampler.
`timescale 1ns / 1ps
`include "linear_interp_resampler_top_defines.svh"

module lir_ctrl #(
  parameter int MAX_CH      = lir_pkg::MAX_CH_DEF,
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [lir_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           last_sample_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           pipe_free_i,
  output logic                           acc_o,
  output logic [IDX_W-1:0]               ch_o,
  output logic [SAMPLE_BITS-1:0]         cur_o,
  output lir_pkg::lir_tag_t              tag_o
);

  localparam logic [lir_pkg::CNT_W:0] MAX_CNT  = (lir_pkg::CNT_W + 1)'(MAX_CH);
  localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(MAX_CH - 1);

  logic [lir_pkg::CNT_W-1:0]  cnt_q;
  logic [lir_pkg::STEP_W-1:0] step_q;
  logic [IDX_W-1:0]           chidx_q, chidx_d;
  logic [lir_pkg::SKIP_W-1:0] skip_q, skip_d;
  logic [lir_pkg::FRAC_W-1:0] phase_q, phase_d;
  logic                       first_q, first_d;

  logic [lir_pkg::CNT_W:0]    cnt_eff;
  logic [IDX_W-1:0]           ch;
  logic                       close;
  logic [lir_pkg::STEP_W-1:0] step_eff;
  logic [lir_pkg::SKIP_W-1:0] whole;
  logic [lir_pkg::FRAC_W-1:0] part;
  logic [lir_pkg::FRAC_W:0]   sum;
  logic                       emit;
  logic                       acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= lir_pkg::CNT_W'(1);
      step_q <= lir_pkg::STEP_ONE;
    end else if (cfg_valid_i) begin
      unique case (lir_pkg::cfg_reg_e'(cfg_index_i))
        lir_pkg::CFG_CHANNEL_COUNT: cnt_q  <= cfg_data_i[lir_pkg::CNT_W-1:0];
        lir_pkg::CFG_STEP_RATIO:    step_q <= cfg_data_i[lir_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the channel count and the step into their legal ranges.
  always_comb begin
    cnt_eff = {1'b0, cnt_q};
    if (cnt_eff == '0) begin
      cnt_eff = (lir_pkg::CNT_W + 1)'(1);
    end else if (cnt_eff > MAX_CNT) begin
      cnt_eff = MAX_CNT;
    end
  end

  assign step_eff = (step_q < lir_pkg::STEP_ONE) ? lir_pkg::STEP_ONE : step_q;
  assign whole    = step_eff[lir_pkg::STEP_W-1:lir_pkg::FRAC_W];
  assign part     = step_eff[lir_pkg::FRAC_W-1:0];
  assign sum      = {1'b0, phase_q} + {1'b0, part};

  assign ch    = (chidx_q > IDX_LAST) ? IDX_LAST : chidx_q;
  assign close = ((lir_pkg::CNT_W + 1)'(ch) + (lir_pkg::CNT_W + 1)'(1)) >= cnt_eff;
  assign emit  = first_q || (skip_q == '0);

  assign acc        = in_valid_i && pipe_free_i;
  assign in_stall_o = !pipe_free_i;

  always_comb begin
    chidx_d = chidx_q;
    skip_d  = skip_q;
    phase_d = phase_q;
    first_d = first_q;
    if (acc) begin
      if (close) begin
        chidx_d = '0;
        if (first_q) begin
          skip_d  = whole;
          phase_d = part;
          first_d = 1'b0;
        end else if (skip_q == '0) begin
          phase_d = sum[lir_pkg::FRAC_W-1:0];
          skip_d  = whole + lir_pkg::SKIP_W'(sum[lir_pkg::FRAC_W]) - lir_pkg::SKIP_W'(1);
        end else begin
          skip_d = skip_q - lir_pkg::SKIP_W'(1);
        end
      end else begin
        chidx_d = ch + IDX_W'(1);
      end
      // The final beat restarts the stream, even in mid-frame.
      if (last_sample_i) begin
        chidx_d = '0;
        skip_d  = '0;
        phase_d = '0;
        first_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chidx_q <= '0;
      skip_q  <= '0;
      phase_q <= '0;
      first_q <= 1'b1;
    end else begin
      chidx_q <= chidx_d;
      skip_q  <= skip_d;
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

  assign acc_o       = acc;
  assign ch_o        = ch;
  assign cur_o       = sample_i[SAMPLE_BITS-1:0];
  assign tag_o.emit  = emit;
  assign tag_o.first = first_q;
  assign tag_o.last  = last_sample_i;
  assign tag_o.chan  = lir_pkg::CHAN_W'(ch);
  assign tag_o.frac  = phase_q;

  `LIR_ASSERT(a_last_restarts, acc && last_sample_i |=> first_q && chidx_q == '0 && skip_q == '0 && phase_q == '0, "final beat did not restart the stream")
  `LIR_ASSERT(a_chidx_range, chidx_q <= IDX_LAST, "channel index beyond channel limit")
  `LIR_ASSERT(a_first_close, acc && first_q && close && !last_sample_i |=> !first_q && skip_q == $past(whole), "first frame close loaded wrong skip")

endmodule

// ===== rtl/lir_blend.sv =====
// Interpolation datapath: multiply, round and output register with stall propagation.
`timescale 1ns / 1ps
`include "linear_interp_resampler_top_defines.svh"

module lir_blend #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  lir_pkg::lir_tag_t             tag_i,
  input  logic [SAMPLE_BITS-1:0]        cur_i,
  input  logic [SAMPLE_BITS-1:0]        prev_i,
  output logic                          pipe_free_o,
  output logic [lir_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic [lir_pkg::CHAN_W-1:0]    out_channel_o,
  output logic                          sample_valid_o,
  output logic                          end_of_stream_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);

  localparam int NW = SAMPLE_BITS + 18;

  logic                           s1_v_q;
  lir_pkg::lir_tag_t              s1_tag_q;
  logic signed [SAMPLE_BITS-1:0]  s1_cur_q;
  logic                           s2_v_q;
  lir_pkg::lir_tag_t              s2_tag_q;
  logic signed [SAMPLE_BITS-1:0]  s2_prev_q;
  logic signed [NW-1:0]           s2_prod_q;
  logic                           out_v_q;
  logic [lir_pkg::SAMPLE_W-1:0]   out_smp_q;
  logic [lir_pkg::CHAN_W-1:0]     out_chan_q;
  logic                           out_sv_q;
  logic                           out_eos_q;

  logic                           out_free, s2_free, s1_free;
  logic signed [SAMPLE_BITS-1:0]  prev_eff;
  logic signed [SAMPLE_BITS:0]    diff;
  logic signed [lir_pkg::FRAC_W:0] frac_s;
  logic signed [NW-1:0]           prod;
  logic signed [NW-1:0]           prev_w, num, rnd, sumr;
  logic signed [SAMPLE_BITS-1:0]  res;

  // A stage takes a new beat when it is empty or its content moves on.
  assign out_free    = !out_v_q || !out_stall_i;
  assign s2_free     = !s2_v_q || out_free;
  assign s1_free     = !s1_v_q || s2_free;
  assign pipe_free_o = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= acc_i && (tag_i.emit || tag_i.last);
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Frame zero passes through: blend the sample with itself at zero fraction.
  assign prev_eff = s1_tag_q.first ? s1_cur_q : $signed(prev_i);
  assign diff     = {s1_cur_q[SAMPLE_BITS-1], s1_cur_q} - {prev_eff[SAMPLE_BITS-1], prev_eff};
  assign frac_s   = s1_tag_q.first ? '0 : $signed({1'b0, s1_tag_q.frac});
  assign prod     = diff * frac_s;

  assign prev_w = NW'(s2_prev_q);
  assign num    = (prev_w <<< lir_pkg::FRAC_W) + s2_prod_q;
  assign rnd    = num[NW-1] ? NW'(32767) : NW'(32768);
  assign sumr   = num + rnd;
  assign res    = sumr[SAMPLE_BITS+lir_pkg::FRAC_W-1:lir_pkg::FRAC_W];

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_tag_q <= tag_i;
      s1_cur_q <= cur_i;
    end
    if (s2_free && s1_v_q) begin
      s2_tag_q  <= s1_tag_q;
      s2_prev_q <= prev_eff;
      s2_prod_q <= prod;
    end
    if (out_free && s2_v_q) begin
      out_smp_q  <= s2_tag_q.emit ? lir_pkg::SAMPLE_W'(res) : '0;
      out_chan_q <= s2_tag_q.chan;
      out_sv_q   <= s2_tag_q.emit;
      out_eos_q  <= s2_tag_q.last;
    end
  end

  assign out_valid_o     = out_v_q;
  assign out_sample_o    = out_smp_q;
  assign out_channel_o   = out_chan_q;
  assign sample_valid_o  = out_sv_q;
  assign end_of_stream_o = out_eos_q;

  `LIR_ASSERT(a_marker_form, out_v_q && !out_sv_q |-> out_eos_q && out_smp_q == '0, "bare marker malformed")
  `LIR_ASSERT(a_s2_hold, s2_v_q && !s2_free |=> s2_v_q, "stalled beat dropped from stage two")
  `LIR_ASSERT(a_first_emits, s1_v_q && s1_tag_q.first |-> s1_tag_q.emit, "frame zero beat without sample")

endmodule

// ===== rtl/linear_interp_resampler_top.sv =====
// Top level of the linear interpolation resampler.
`timescale 1ns / 1ps

// Linear interpolation resampler for interleaved multichannel audio. One
// signed sample enters per beat, channels in frame order, and the block takes
// a new beat every cycle while in_stall is low. A result passes, in order,
// through the registered read of the per-channel held-sample memory, the
// difference times fraction multiply, and the add and round half away
// from zero. Frame zero of a stream passes through; later output frames
// blend the previous and current frame at the 8.16 position set by
// step_ratio, and skipped frames give no result. The beat with last_sample
// always yields a result flagged end_of_stream (sample_valid low when it
// carries no sample) and restarts the stream. Three result slots sit between
// input and output, so input stall rises only when those are full and the
// output is stalled. Write channel_count and step_ratio only while idle.
module linear_interp_resampler_top #(
  parameter int MAX_CH      = lir_pkg::MAX_CH_DEF,
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input sample beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lir_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           last_sample_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lir_pkg::SAMPLE_W-1:0]   out_sample_o,
  output logic [lir_pkg::CHAN_W-1:0]     out_channel_o,
  output logic                           sample_valid_o,
  output logic                           end_of_stream_o
);

  localparam int IDX_W = (MAX_CH > 1) ? $clog2(MAX_CH) : 1;

  logic                   acc;
  logic                   pipe_free;
  logic [IDX_W-1:0]       ch;
  logic [SAMPLE_BITS-1:0] cur;
  logic [SAMPLE_BITS-1:0] prev;
  lir_pkg::lir_tag_t      tag;

  // Position tracking, registers and input handshake.
  lir_ctrl #(
    .MAX_CH      (MAX_CH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pipe_free_i   (pipe_free),
    .acc_o         (acc),
    .ch_o          (ch),
    .cur_o         (cur),
    .tag_o         (tag)
  );

  // Every accepted beat reads the channel's previous sample and stores the new one.
  lir_mem #(
    .DEPTH  (MAX_CH),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (acc),
    .addr_i  (ch),
    .wdata_i (cur),
    .rdata_o (prev)
  );

  // Blend, round and hold the result until it is taken.
  lir_blend #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_blend (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (acc),
    .tag_i           (tag),
    .cur_i           (cur),
    .prev_i          (prev),
    .pipe_free_o     (pipe_free),
    .out_sample_o    (out_sample_o),
    .out_channel_o   (out_channel_o),
    .sample_valid_o  (sample_valid_o),
    .end_of_stream_o (end_of_stream_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule
